[hdl/i2crtc_pkg.sv]
// Shared types, constants and BCD calendar functions for the serial-bus calendar clock.
package i2crtc_pkg;

	// Request codes as they arrive on the request channel.
	localparam logic [2:0] REQ_START_WR = 3'd0;
	localparam logic [2:0] REQ_START_RD = 3'd1;
	localparam logic [2:0] REQ_WRITE    = 3'd2;
	localparam logic [2:0] REQ_READ     = 3'd3;
	localparam logic [2:0] REQ_STOP     = 3'd4;
	localparam logic [2:0] REQ_TICK     = 3'd5;

	// Register map.
	localparam logic [3:0] REG_SECONDS  = 4'd1;
	localparam logic [3:0] REG_TIME_END = 4'd8;
	localparam logic [3:0] REG_TRICKLE  = 4'd10;
	localparam logic [3:0] REG_STATUS   = 4'd11;
	localparam logic [3:0] REG_CTRL     = 4'd12;
	localparam logic [3:0] LAST_REG     = 4'd12;

	localparam logic [7:0] CTRL_MASK    = 8'h9f;
	localparam int unsigned CTRL_STOP_BIT = 7;
	localparam logic [7:0] FLAG_BITS    = 8'hc0;
	localparam logic [7:0] FLAG_RESET   = 8'h80;
	localparam logic [3:0] TRICKLE_KEY  = 4'ha;

	// Time registers 0..7: hundredths, seconds, minutes, hours, weekday, date, month, year.
	typedef logic [7:0][7:0] rtc_time_t;
	localparam rtc_time_t START_TIME = 64'h00010101_00000000;

	typedef enum logic [2:0] {
		OP_START_WR,
		OP_START_RD,
		OP_WRITE,
		OP_READ,
		OP_STOP,
		OP_TICK,
		OP_NONE
	} op_t;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              push;
		logic              pop;
	} q_stat_t;

	function automatic logic [7:0] dec_of(logic [7:0] b);
		return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
	endfunction

	// Binary to BCD for values below 100, by a reciprocal multiply.
	function automatic logic [7:0] bcd_of(logic [7:0] v);
		logic [15:0] p;
		logic [4:0]  q;
		logic [7:0]  r;
		p = 16'(v) * 16'd205;
		q = p[15:11];
		r = v - 8'(q) * 8'd10;
		return {q[3:0], r[3:0]};
	endfunction

	// Counts a field up; bit 8 of the result is the carry.
	function automatic logic [8:0] count(logic [7:0] f, logic [7:0] lo, logic [7:0] top);
		logic [7:0] v;
		v = dec_of(f);
		if (v >= top) begin
			return {1'b1, bcd_of(lo)};
		end
		return {1'b0, bcd_of(v + 8'd1)};
	endfunction

	function automatic logic [7:0] month_days(logic [7:0] m);
		case (m)
			8'd2:                      return 8'd28;
			8'd4, 8'd6, 8'd9, 8'd11:   return 8'd30;
			default:                   return 8'd31;
		endcase
	endfunction

	// One 10 ms step of the calendar.
	function automatic rtc_time_t advance(rtc_time_t t_in);
		rtc_time_t  t;
		logic [8:0] c;
		logic [7:0] h;
		logic [7:0] b;
		logic [7:0] m;
		logic [7:0] y;
		logic [7:0] dim;
		logic       pm;
		logic       carry;
		t = t_in;
		c = count(t[0], 8'd0, 8'd99);
		t[0] = c[7:0];
		if (!c[8]) return t;
		c = count(t[1], 8'd0, 8'd59);
		t[1] = c[7:0];
		if (!c[8]) return t;
		c = count(t[2], 8'd0, 8'd59);
		t[2] = c[7:0];
		if (!c[8]) return t;
		if (t[3][6]) begin
			h = dec_of({3'b000, t[3][4:0]});
			pm = t[3][5];
			carry = 1'b0;
			if (h == 8'd11) begin
				h = 8'd12;
				carry = pm;
				pm = !pm;
			end else if (h >= 8'd12) begin
				h = 8'd1;
			end else begin
				h = h + 8'd1;
			end
			b = bcd_of(h);
			t[3] = {1'b0, 1'b1, pm, b[4:0]};
			if (!carry) return t;
		end else begin
			h = dec_of({2'b00, t[3][5:0]});
			if (h >= 8'd23) begin
				t[3] = 8'd0;
			end else begin
				t[3] = bcd_of(h + 8'd1);
				return t;
			end
		end
		t[4] = (t[4] == 8'd0 || t[4] >= 8'd7) ? 8'd1 : t[4] + 8'd1;
		m = dec_of({3'b000, t[6][4:0]});
		y = dec_of(t[7]);
		dim = month_days(m);
		if (m == 8'd2 && y[1:0] == 2'b00) dim = 8'd29;
		c = count(t[5], 8'd1, dim);
		t[5] = c[7:0];
		if (!c[8]) return t;
		c = count(t[6], 8'd1, 8'd12);
		t[6] = c[7:0];
		if (!c[8]) return t;
		c = count(t[7], 8'd0, 8'd99);
		t[7] = c[7:0];
		return t;
	endfunction

endpackage

[hdl/i2crtc_if.sv]
// Request and response channel interfaces of the calendar clock.
interface i2crtc_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] data_in;
	modport source(output valid, output req_type, output data_in, input ready);
	modport sink(input valid, input req_type, input data_in, output ready);
endinterface

interface i2crtc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       ack;
	logic       charge_error;
	modport source(output valid, output read_data, output ack, output charge_error, input ready);
	modport sink(input valid, input read_data, input ack, input charge_error, output ready);
endinterface

[hdl/i2c_bcd_calendar_clock.sv]
// Top level of the serial-bus BCD calendar clock: front end, operation queue and back end.
//
//   Channel   Role     Carries
//   req_ch    sink     req_type (start write/read, write, read, stop, tick), data_in
//   rsp_ch    source   read_data, ack, charge_error (one response per request)
//   cfg       write    cfg_we / cfg_wdata set the battery chargeable bit
//
// The block sustains one request per cycle while rsp_ch takes its responses; the back end
// register update and the BCD carry chain of a tick are combinational. A request accepted
// by the front end is written into the two-entry queue and then executed from the queue
// head, which loads the response register that drives rsp_ch.
// The asynchronous reset puts the clock at 2000-01-01 00:00:00.00, weekday 1, with the
// oscillator stop flag set; no clearing pass is needed.
// A stalled response side fills the queue and then drops req_ch.ready; a stalled request
// side lets the back end drain the queue on its own.
module i2c_bcd_calendar_clock (
	input  logic         clk,
	input  logic         arst_n,
	i2crtc_req_if.sink   req_ch,
	i2crtc_rsp_if.source rsp_ch,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	logic                push;
	logic                full;
	logic                pop;
	i2crtc_pkg::entry_t  push_entry;
	i2crtc_pkg::q_head_t head;
	i2crtc_pkg::q_stat_t stat;

	// The front end only decodes the request type; all calendar and register state lives in the back end.
	i2crtc_front u_front (
		.req        (req_ch),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	i2crtc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.stat       (stat)
	);

	// The back end executes the queue head whenever its response register is free or drains.
	i2crtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.rsp       (rsp_ch)
	);

	// The queue never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= i2crtc_pkg::QCNT_W'(i2crtc_pkg::QDEPTH))
		else $error("queue count beyond depth");

	// A request taken without a pop grows the queue by one.
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.push && !stat.pop) |=> stat.count == i2crtc_pkg::QCNT_W'($past(stat.count) + 1'b1))
		else $error("queue count did not follow a push");

	// A response appears only after the back end executed a request.
	a_rsp_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_ch.valid) |-> $past(stat.pop))
		else $error("response without an executed request");

	// A waiting request with a free response register is executed at once.
	a_no_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.count != '0 && !rsp_ch.valid) |-> stat.pop)
		else $error("back end idle with work queued");

endmodule

[hdl/i2crtc_front.sv]
// Front end: accepts requests and classifies them into operations for the queue.
module i2crtc_front (
	i2crtc_req_if.sink          req,
	input  logic                full,
	output logic                push,
	output i2crtc_pkg::entry_t  push_entry
);

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		push_entry.data = req.data_in;
		unique case (req.req_type)
			i2crtc_pkg::REQ_START_WR: push_entry.op = i2crtc_pkg::OP_START_WR;
			i2crtc_pkg::REQ_START_RD: push_entry.op = i2crtc_pkg::OP_START_RD;
			i2crtc_pkg::REQ_WRITE:    push_entry.op = i2crtc_pkg::OP_WRITE;
			i2crtc_pkg::REQ_READ:     push_entry.op = i2crtc_pkg::OP_READ;
			i2crtc_pkg::REQ_STOP:     push_entry.op = i2crtc_pkg::OP_STOP;
			i2crtc_pkg::REQ_TICK:     push_entry.op = i2crtc_pkg::OP_TICK;
			default:                  push_entry.op = i2crtc_pkg::OP_NONE;
		endcase
	end

endmodule

[hdl/i2crtc_queue.sv]
// Short queue of classified operations between the front and back ends.
module i2crtc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  i2crtc_pkg::entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output i2crtc_pkg::q_head_t head,
	output i2crtc_pkg::q_stat_t stat
);

	i2crtc_pkg::entry_t                    mem_q [i2crtc_pkg::QDEPTH];
	logic [i2crtc_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [i2crtc_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [i2crtc_pkg::QCNT_W-1:0]         count_q;

	function automatic logic [i2crtc_pkg::QPTR_W-1:0] next_ptr(
		logic [i2crtc_pkg::QPTR_W-1:0] p);
		return (p == i2crtc_pkg::QPTR_W'(i2crtc_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = count_q == i2crtc_pkg::QCNT_W'(i2crtc_pkg::QDEPTH);
	assign head.valid = count_q != '0;
	assign head.entry = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.push  = push;
	assign stat.pop   = pop;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/i2crtc_back.sv]
// Back end: register file, shadow and live time, calendar counters and response register.
module i2crtc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  i2crtc_pkg::q_head_t head,
	output logic                pop,
	i2crtc_rsp_if.source        rsp
);

	logic [3:0]            ptr_q;
	logic                  expect_q;
	logic                  wdir_q;
	logic                  tw_q;
	logic                  ssc_q;
	i2crtc_pkg::rtc_time_t shadow_q;
	i2crtc_pkg::rtc_time_t live_q;
	logic [7:0]            control_q;
	logic [7:0]            trickle_q;
	logic [7:0]            flag_q;
	logic                  batt_q;

	logic                  out_valid_q;
	logic [7:0]            rd_q;
	logic                  ack_q;
	logic                  cerr_q;

	logic [3:0]            n_ptr;
	logic                  n_expect;
	logic                  n_wdir;
	logic                  n_tw;
	logic                  n_ssc;
	i2crtc_pkg::rtc_time_t n_shadow;
	i2crtc_pkg::rtc_time_t n_live;
	logic [7:0]            n_control;
	logic [7:0]            n_trickle;
	logic [7:0]            n_flag;
	logic [7:0]            rd;
	logic                  ack;
	logic                  cerr;
	logic                  running;
	logic                  wrap;
	logic [3:0]            ptr_inc;
	logic [7:0]            reg_rd;
	logic [7:0]            d;

	assign pop     = head.valid && (!out_valid_q || rsp.ready);
	assign running = !control_q[i2crtc_pkg::CTRL_STOP_BIT];
	assign wrap    = ptr_q >= i2crtc_pkg::LAST_REG;
	assign ptr_inc = wrap ? 4'd0 : ptr_q + 4'd1;
	assign d       = head.entry.data;

	always_comb begin
		if (ptr_q < i2crtc_pkg::REG_TIME_END) begin
			reg_rd = shadow_q[ptr_q[2:0]];
		end else begin
			unique case (ptr_q)
				i2crtc_pkg::REG_TRICKLE: reg_rd = trickle_q;
				i2crtc_pkg::REG_STATUS:  reg_rd = flag_q;
				i2crtc_pkg::REG_CTRL:    reg_rd = control_q;
				default:                 reg_rd = 8'd0;
			endcase
		end
	end

	always_comb begin
		n_ptr     = ptr_q;
		n_expect  = expect_q;
		n_wdir    = wdir_q;
		n_tw      = tw_q;
		n_ssc     = ssc_q;
		n_shadow  = shadow_q;
		n_live    = live_q;
		n_control = control_q;
		n_trickle = trickle_q;
		n_flag    = flag_q;
		rd        = 8'd0;
		ack       = 1'b1;
		cerr      = 1'b0;
		unique case (head.entry.op) inside
			i2crtc_pkg::OP_START_WR, i2crtc_pkg::OP_START_RD: begin
				n_expect = 1'b1;
				n_wdir   = head.entry.op == i2crtc_pkg::OP_START_WR;
				if (running) n_shadow = live_q;
				n_tw     = 1'b0;
				n_ssc    = 1'b0;
			end
			i2crtc_pkg::OP_WRITE: begin
				if (expect_q) begin
					if (d > {4'd0, i2crtc_pkg::LAST_REG}) begin
						ack = 1'b0;
					end else begin
						n_ptr    = d[3:0];
						n_expect = 1'b0;
					end
				end else begin
					if (ptr_q < i2crtc_pkg::REG_TIME_END) begin
						n_shadow[ptr_q[2:0]] = d;
						n_tw = 1'b1;
						if (ptr_q <= i2crtc_pkg::REG_SECONDS) n_ssc = 1'b1;
					end else if (ptr_q == i2crtc_pkg::REG_TRICKLE) begin
						n_trickle = d;
						cerr = d[7:4] == i2crtc_pkg::TRICKLE_KEY
							&& (d[3:2] == 2'd1 || d[3:2] == 2'd2)
							&& d[1:0] != 2'd0 && !batt_q;
					end else if (ptr_q == i2crtc_pkg::REG_STATUS) begin
						n_flag = flag_q & (d | ~i2crtc_pkg::FLAG_BITS) & i2crtc_pkg::FLAG_BITS;
					end else if (ptr_q == i2crtc_pkg::REG_CTRL) begin
						n_control = d & i2crtc_pkg::CTRL_MASK;
					end
					n_ptr = ptr_inc;
				end
			end
			i2crtc_pkg::OP_READ: begin
				rd    = reg_rd;
				n_ptr = ptr_inc;
				if (wrap && running) n_shadow = live_q;
			end
			i2crtc_pkg::OP_STOP: begin
				if (wdir_q && tw_q) begin
					n_live = shadow_q;
					if (ssc_q) n_live[0] = 8'd0;
				end
				n_tw     = 1'b0;
				n_ssc    = 1'b0;
				n_expect = 1'b1;
			end
			i2crtc_pkg::OP_TICK: begin
				if (running) n_live = i2crtc_pkg::advance(live_q);
			end
			default: begin
				ack = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= 4'd0;
			expect_q  <= 1'b1;
			wdir_q    <= 1'b0;
			tw_q      <= 1'b0;
			ssc_q     <= 1'b0;
			shadow_q  <= i2crtc_pkg::START_TIME;
			live_q    <= i2crtc_pkg::START_TIME;
			control_q <= 8'd0;
			trickle_q <= 8'd0;
			flag_q    <= i2crtc_pkg::FLAG_RESET;
			batt_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) batt_q <= cfg_wdata;
			if (pop) begin
				ptr_q     <= n_ptr;
				expect_q  <= n_expect;
				wdir_q    <= n_wdir;
				tw_q      <= n_tw;
				ssc_q     <= n_ssc;
				shadow_q  <= n_shadow;
				live_q    <= n_live;
				control_q <= n_control;
				trickle_q <= n_trickle;
				flag_q    <= n_flag;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q   <= rd;
			ack_q  <= ack;
			cerr_q <= cerr;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = rd_q;
	assign rsp.ack          = ack_q;
	assign rsp.charge_error = cerr_q;

endmodule
